// ===== rtl/etc_pkg.sv =====
// Package for the extruder thermostat controller: payload types, register indexes, segment table.
`default_nettype none
package etc_pkg;

	// Number of display positions that may light; positions at or above it stay blank.
	localparam int DISPLAY_DIGITS = 4;

	localparam logic [6:0] SEG_BLANK = 7'h7F;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HYST_BAND   = 2'd0;
	localparam logic [1:0] CFG_SETTLE_MS   = 2'd1;
	localparam logic [1:0] CFG_MOTOR_SPEED = 2'd2;

	localparam logic [7:0] RST_HYST_BAND   = 8'd2;
	localparam logic [15:0] RST_SETTLE_MS  = 16'd2000;
	localparam logic [7:0] RST_MOTOR_SPEED = 8'd255;

	typedef struct packed {
		logic [9:0]         knob_raw;
		logic signed [11:0] temperature;
		logic [31:0]        now_ms;
	} etc_in_t;

	typedef struct packed {
		logic               heater_on;
		logic               motor_run;
		logic [7:0]         motor_drive;
		logic               showing_knob;
		logic signed [11:0] shown_value;
		logic [6:0]         digit_thousands;
		logic [6:0]         digit_hundreds;
		logic [6:0]         digit_tens;
		logic [6:0]         digit_ones;
		logic [7:0]         active_setpoint;
	} etc_out_t;

	typedef struct packed {
		logic [6:0] thousands;
		logic [6:0] hundreds;
		logic [6:0] tens;
		logic [6:0] ones;
	} etc_digits_t;

	// Active-high segment patterns A..G plus a spare low bit, one per decimal digit.
	function automatic logic [7:0] seg_raw(input logic [3:0] d);
		logic [7:0] r;
		case (d)
			4'd0: r = 8'hFC;
			4'd1: r = 8'h60;
			4'd2: r = 8'hDA;
			4'd3: r = 8'hF2;
			4'd4: r = 8'h66;
			4'd5: r = 8'hB6;
			4'd6: r = 8'h3E;
			4'd7: r = 8'hE0;
			4'd8: r = 8'hFE;
			4'd9: r = 8'hE6;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// Active-low A..G image of one decimal digit.
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [7:0] r;
		r = seg_raw(d);
		return ~r[7:1];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/etc_display.sv =====
// Decimal split and seven-segment encoding of the displayed value.
`default_nettype none
module etc_display (
	input  wire logic signed [11:0] shown,
	output etc_pkg::etc_digits_t    digits
);

	logic [10:0] n;
	logic [26:0] p_ten;
	logic [26:0] p_hun;
	logic [26:0] p_thou;
	logic [7:0]  q1;
	logic [4:0]  q2;
	logic [1:0]  q3;
	logic [10:0] d0_w;
	logic [7:0]  d1_w;
	logic [4:0]  d2_w;
	logic        non_neg;

	assign non_neg = !shown[11];
	assign n       = shown[10:0];

	// Reciprocal multiplies; exact for every value below 2048.
	assign p_ten  = 27'(n) * 27'd52429;
	assign p_hun  = 27'(n) * 27'd5243;
	assign p_thou = 27'(n) * 27'd8389;
	assign q1 = p_ten[26:19];
	assign q2 = p_hun[23:19];
	assign q3 = p_thou[24:23];

	assign d0_w = n - 11'(q1) * 11'd10;
	assign d1_w = q1 - 8'(q2) * 8'd10;
	assign d2_w = q2 - 5'(q3) * 5'd10;

	// The ones digit lights for zero too; a higher digit only under a nonzero quotient.
	always_comb begin
		digits.ones      = etc_pkg::SEG_BLANK;
		digits.tens      = etc_pkg::SEG_BLANK;
		digits.hundreds  = etc_pkg::SEG_BLANK;
		digits.thousands = etc_pkg::SEG_BLANK;
		if (non_neg) begin
			if (etc_pkg::DISPLAY_DIGITS > 0) begin
				digits.ones = etc_pkg::seg_of(d0_w[3:0]);
			end
			if (etc_pkg::DISPLAY_DIGITS > 1 && q1 != 8'd0) begin
				digits.tens = etc_pkg::seg_of(d1_w[3:0]);
			end
			if (etc_pkg::DISPLAY_DIGITS > 2 && q2 != 5'd0) begin
				digits.hundreds = etc_pkg::seg_of(d2_w[3:0]);
			end
			if (etc_pkg::DISPLAY_DIGITS > 3 && q3 != 2'd0) begin
				digits.thousands = etc_pkg::seg_of({2'b00, q3});
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/extruder_thermostat_controller_top.sv =====
// Top level of the extruder thermostat controller: input stage, control pass, result register.
//
// Usage: each item on the in channel is one control pass (knob reading, temperature,
// millisecond timestamp). Each item yields exactly one result item on the out channel
// carrying heater and motor drive, the displayed value and its four segment digits, and
// the setpoint in force after the pass.
// An accepted item enters the input register, then the result register once that is
// free or being taken; out_valid rises when the result register holds it. Throughput: one
// item per cycle while the receiver does not stall; the controller state (setpoint,
// pending knob change, heater) updates as each item moves from the input register into
// the result register, so items may follow back to back.
// When the receiver stalls, the result register holds its item and the input register
// keeps one more; in_ready drops only when both are full and out_ready is low.
// The cfg channel is always ready; registers take effect at once. The user must write
// them only while no item is in flight; the block does not enforce this. Index 3 is ignored.
// Reset clears the pipeline, the controller state and loads the register defaults
// (band 2, settle 2000 ms, motor speed 255). The first item after reset loads the
// quantized knob as the setpoint.
`default_nettype none
module extruder_thermostat_controller_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire etc_pkg::etc_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output etc_pkg::etc_out_t     out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [15:0]      cfg_data
);

	// Configuration registers.
	logic [7:0]  band_q;
	logic [15:0] settle_q;
	logic [7:0]  speed_q;

	// Controller state.
	logic [7:0]  setpoint_q;
	logic        loaded_q;
	logic        pending_q;
	logic [7:0]  pend_val_q;
	logic [31:0] pend_start_q;
	logic        heater_q;

	logic             valid_s1;
	etc_pkg::etc_in_t data_s1;
	logic             advance;

	logic [25:0]        knob_prod;
	logic [5:0]         knob_q20;
	logic [7:0]         knob;
	logic [7:0]         sp_cur;
	logic signed [12:0] diff;
	logic signed [12:0] band_s;
	logic               heater_next;
	logic               run;
	logic               show_knob;
	logic [31:0]        elapsed;
	logic               settled;
	logic [7:0]         sp_next;
	logic               pending_next;
	logic [7:0]         pend_val_next;
	logic [31:0]        pend_start_next;
	logic signed [11:0] shown;
	etc_pkg::etc_digits_t digits;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q   <= etc_pkg::RST_HYST_BAND;
			settle_q <= etc_pkg::RST_SETTLE_MS;
			speed_q  <= etc_pkg::RST_MOTOR_SPEED;
		end else if (cfg_valid) begin
			case (cfg_index)
				etc_pkg::CFG_HYST_BAND:   band_q   <= cfg_data[7:0];
				etc_pkg::CFG_SETTLE_MS:   settle_q <= cfg_data;
				etc_pkg::CFG_MOTOR_SPEED: speed_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Knob quantization: (raw / 20) * 5 by a reciprocal multiply.
	assign knob_prod = 26'(data_s1.knob_raw) * 26'd3277;
	assign knob_q20  = knob_prod[21:16];
	assign knob      = {knob_q20, 2'b00} + {2'b00, knob_q20};

	assign sp_cur = loaded_q ? setpoint_q : knob;
	assign band_s = $signed({5'b00000, band_q});
	assign diff   = $signed({5'b00000, sp_cur})
		- $signed({data_s1.temperature[11], data_s1.temperature});

	// Heater on at or below setpoint minus band, off up to the band above it, held above that.
	always_comb begin
		heater_next = heater_q;
		if (diff >= band_s) begin
			heater_next = 1'b1;
		end else if (diff >= -band_s) begin
			heater_next = 1'b0;
		end
	end
	assign run = (diff <= band_s);

	assign show_knob = (knob != sp_cur);
	assign elapsed   = data_s1.now_ms - pend_start_q;
	assign settled   = (elapsed >= {16'h0000, settle_q});

	always_comb begin
		sp_next         = sp_cur;
		pending_next    = pending_q;
		pend_val_next   = pend_val_q;
		pend_start_next = pend_start_q;
		if (show_knob) begin
			if (!pending_q) begin
				pending_next    = 1'b1;
				pend_val_next   = knob;
				pend_start_next = data_s1.now_ms;
			end else if (settled) begin
				if (pend_val_q == knob) begin
					sp_next      = pend_val_q;
					pending_next = 1'b0;
				end else begin
					pend_val_next   = knob;
					pend_start_next = data_s1.now_ms;
				end
			end
		end
	end

	assign shown = show_knob ? $signed({4'b0000, knob}) : data_s1.temperature;

	etc_display u_display (
		.shown  (shown),
		.digits (digits)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= 8'd0;
			loaded_q     <= 1'b0;
			pending_q    <= 1'b0;
			pend_val_q   <= 8'd0;
			pend_start_q <= 32'd0;
			heater_q     <= 1'b0;
		end else if (advance) begin
			setpoint_q   <= sp_next;
			loaded_q     <= 1'b1;
			pending_q    <= pending_next;
			pend_val_q   <= pend_val_next;
			pend_start_q <= pend_start_next;
			heater_q     <= heater_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.heater_on       <= heater_next;
			out_data.motor_run       <= run;
			out_data.motor_drive     <= run ? speed_q : 8'd0;
			out_data.showing_knob    <= show_knob;
			out_data.shown_value     <= shown;
			out_data.digit_thousands <= digits.thousands;
			out_data.digit_hundreds  <= digits.hundreds;
			out_data.digit_tens      <= digits.tens;
			out_data.digit_ones      <= digits.ones;
			out_data.active_setpoint <= sp_next;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/etc_checker.sv =====
// Port-level checks for the extruder thermostat controller, bound to the top level.
`default_nettype none
module etc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire etc_pkg::etc_out_t out_data
);

	// A stalled result item stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result item changed while stalled");

	// A stopped motor gets no drive.
	a_motor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.motor_run |-> out_data.motor_drive == 8'd0)
		else $error("motor drive without motor run");

	// A negative value shows as four blank digits.
	a_neg_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.shown_value[11] |->
			out_data.digit_thousands == etc_pkg::SEG_BLANK &&
			out_data.digit_hundreds == etc_pkg::SEG_BLANK &&
			out_data.digit_tens == etc_pkg::SEG_BLANK &&
			out_data.digit_ones == etc_pkg::SEG_BLANK)
		else $error("negative value not blanked");

	// A knob value on the display is at most 255, so it never lights the thousands digit.
	a_knob_shown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.showing_knob |->
			out_data.shown_value[11:8] == 4'd0 &&
			out_data.digit_thousands == etc_pkg::SEG_BLANK)
		else $error("knob value out of range");

endmodule

bind extruder_thermostat_controller_top etc_checker u_etc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
